[rtl/tmps_pkg.sv]
// Shared types and constants for the triangle maximum path sum unit.
// No dependencies.
`timescale 1ns / 1ps

package tmps_pkg;

   localparam int MAX_ROWS    = 128;
   localparam int ROW_W       = $clog2(MAX_ROWS);
   localparam int CNT_W       = $clog2(MAX_ROWS + 1);
   localparam int CSR_W       = 8;
   localparam int WIDE_W      = (CNT_W > CSR_W) ? CNT_W : CSR_W;
   localparam int VALUE_W     = 16;
   localparam int SUM_W       = 23;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_W-1:0] ROW_COUNT_RESET = CSR_W'(15);
   localparam logic [SUM_W-1:0] SUM_MAX         = '1;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [ROW_W-1:0]   col;
      logic               top;
      logic               first_col;
      logic               last_col;
      logic               last_row;
   } entry_type;

endpackage

[rtl/tmps_front.sv]
// Front end: holds row_count, tracks row/column position and tags each word.
// Depends on tmps_pkg.
`timescale 1ns / 1ps

module tmps_front import tmps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [CSR_W-1:0]   csr_write_data,
   input  logic               req_valid,
   input  logic [VALUE_W-1:0] req_value,
   output logic               req_stall,
   input  logic               queue_full,
   output logic               push,
   output entry_type          push_entry
);

   logic [CSR_W-1:0]  row_count_ff;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ROW_W-1:0]  col_ff, col_in;
   logic [WIDE_W-1:0] csr_ext;
   logic [WIDE_W-1:0] rows_eff;
   logic              last_row;
   logic              last_col;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      csr_ext = WIDE_W'(row_count_ff);
      if (row_count_ff == '0) begin
         rows_eff = WIDE_W'(1);
      end else if (csr_ext > WIDE_W'(MAX_ROWS)) begin
         rows_eff = WIDE_W'(MAX_ROWS);
      end else begin
         rows_eff = csr_ext;
      end
   end

   assign last_row = (WIDE_W'(row_ff) + WIDE_W'(1)) >= rows_eff;
   assign last_col = (col_ff == row_ff);

   always_comb begin
      push_entry.value     = req_value;
      push_entry.col       = col_ff;
      push_entry.top       = (row_ff == '0);
      push_entry.first_col = (col_ff == '0);
      push_entry.last_col  = last_col;
      push_entry.last_row  = last_row;
   end

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (push) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + ROW_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= ROW_COUNT_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
      end else begin
         if (csr_write_enable) begin
            row_count_ff <= csr_write_data;
         end
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule

[rtl/tmps_queue.sv]
// Short FIFO of tagged words between front and back.
// Depends on tmps_pkg.
`timescale 1ns / 1ps

module tmps_queue import tmps_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      empty,
   output entry_type head
);

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      next_ptr = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count past depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");

endmodule

[rtl/tmps_back.sv]
// Back end: best_row memory, one read-modify-write per word with bypass,
// running maximum and result register. Depends on tmps_pkg.
`timescale 1ns / 1ps

module tmps_back import tmps_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             empty,
   input  entry_type        head,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [SUM_W-1:0] rsp_max_total
);

   logic [SUM_W-1:0] best_row_mem [MAX_ROWS];

   logic             s1_valid_ff;
   entry_type        s1_entry_ff;
   logic [SUM_W-1:0] rd_data_ff;
   logic             fwd_ff;
   logic [SUM_W-1:0] fwd_data_ff;
   logic [SUM_W-1:0] left_ff;
   logic [SUM_W-1:0] max_ff, max_in;
   logic             rsp_valid_ff;
   logic [SUM_W-1:0] rsp_data_ff;

   logic [SUM_W-1:0] mem_val;
   logic [SUM_W-1:0] above;
   logic [SUM_W-1:0] best;
   logic [SUM_W:0]   sum_wide;
   logic [SUM_W-1:0] sum;
   logic             emit;
   logic             out_free;
   logic             s1_leave;

   assign mem_val = fwd_ff ? fwd_data_ff : rd_data_ff;
   assign above   = s1_entry_ff.last_col ? '0 : mem_val;

   always_comb begin
      if (s1_entry_ff.top) begin
         best = '0;
      end else if (s1_entry_ff.first_col) begin
         best = above;
      end else if (s1_entry_ff.last_col) begin
         best = left_ff;
      end else begin
         best = (left_ff > above) ? left_ff : above;
      end
   end

   assign sum_wide = (SUM_W + 1)'(s1_entry_ff.value) + (SUM_W + 1)'(best);
   assign sum      = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

   always_comb begin
      max_in = max_ff;
      if (s1_entry_ff.last_row && (s1_entry_ff.first_col || sum > max_ff)) begin
         max_in = sum;
      end
   end

   assign emit     = s1_entry_ff.last_row && s1_entry_ff.last_col;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s1_leave = s1_valid_ff && (!emit || out_free);
   assign pop      = !empty && (!s1_valid_ff || s1_leave);

   always_ff @(posedge clock) begin
      if (pop) begin
         rd_data_ff  <= best_row_mem[head.col];
         s1_entry_ff <= head;
         fwd_data_ff <= sum;
      end
      if (s1_leave) begin
         best_row_mem[s1_entry_ff.col] <= sum;
         left_ff                       <= above;
      end
      if (s1_leave && emit) begin
         rsp_data_ff <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            s1_valid_ff <= 1'b1;
            fwd_ff      <= s1_leave && (s1_entry_ff.col == head.col);
         end else if (s1_leave) begin
            s1_valid_ff <= 1'b0;
            fwd_ff      <= 1'b0;
         end
         if (s1_leave) begin
            max_ff <= emit ? '0 : max_in;
         end
         if (s1_leave && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_max_total = rsp_data_ff;

   a_fwd_has_word: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> s1_valid_ff)
      else $error("bypass flag without a word in execute");

   a_hold_only_on_full: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_leave) |-> (rsp_valid_ff && rsp_stall))
      else $error("execute stage held without a stalled result");

   a_result_from_leave: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_leave && emit))
      else $error("result raised without a final word");

endmodule

[rtl/triangle_max_path_sum_unit.sv]
// Top level of the triangle maximum path sum unit: front, queue and back.
// Depends on tmps_pkg, tmps_front, tmps_queue, tmps_back.
//
//   port group  dir  handshake          payload
//   req_        in   req_valid/stall    req_value[15:0]
//   rsp_        out  rsp_valid/stall    rsp_max_total[22:0]
//   csr_        in   csr_write_enable   csr_write_data[7:0] (row_count)
//
// One word per cycle unless a stalled result holds execute, bound by the single
// best_row read-modify-write per word; a same-column write/read pair is bypassed.
// The result register loads when the last word of the triangle leaves execute.
// Synchronous reset clears counters, queue and pipeline; row_count returns to 15.
// best_row is not cleared. A stalled result holds the execute stage only when the
// next result is ready; the 4-word queue keeps req_ accepting meanwhile.
`timescale 1ns / 1ps

module triangle_max_path_sum_unit import tmps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [CSR_W-1:0]   csr_write_data,
   input  logic               req_valid,
   input  logic [VALUE_W-1:0] req_value,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [SUM_W-1:0]   rsp_max_total
);

   logic      push;
   entry_type push_entry;
   logic      queue_full;
   logic      pop;
   logic      empty;
   entry_type head;

   tmps_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_value        (req_value),
      .req_stall        (req_stall),
      .queue_full       (queue_full),
      .push             (push),
      .push_entry       (push_entry)
   );

   tmps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .empty      (empty),
      .head       (head)
   );

   tmps_back u_back (
      .clock         (clock),
      .reset         (reset),
      .empty         (empty),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_max_total (rsp_max_total)
   );

endmodule

[tb/sv/tmps_checker.sv]
// Checker for the triangle maximum path sum unit: watches the csr_, req_ and rsp_ ports,
// predicts each max_total from the accepted words and compares in order.
// Depends on tmps_pkg.
`timescale 1ns / 1ps

module tmps_checker import tmps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [CSR_W-1:0]   csr_write_data,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [VALUE_W-1:0] req_value,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [SUM_W-1:0]   rsp_max_total,
   output int                 failures,
   output int                 pending,
   output int                 totals_checked
);

   logic [CSR_W-1:0] row_count;
   logic [SUM_W-1:0] partial_sums [MAX_ROWS];
   int               cur_row;
   int               cur_col;
   logic [SUM_W-1:0] saved_left;
   logic [SUM_W-1:0] bottom_max;
   logic [SUM_W-1:0] expected_totals [$];

   // one triangle entry: path sum through its better parent, total on the last entry
   function automatic void fold_entry(input logic [VALUE_W-1:0] v);
      int               rows;
      int               r;
      int               c;
      int               s;
      bit               bottom;
      logic [SUM_W-1:0] above;
      logic [SUM_W-1:0] parent;
      logic [SUM_W-1:0] sum;
      rows = (row_count == 0) ? 1 : ((row_count > MAX_ROWS) ? MAX_ROWS : int'(row_count));
      r = cur_row;
      c = cur_col;
      bottom = (r + 1 >= rows);
      if (r >= MAX_ROWS) r = MAX_ROWS - 1;
      if (c > r) c = r;
      above = (c < r) ? partial_sums[c] : '0;
      parent = '0;
      if (r > 0) begin
         if (c == 0) parent = above;
         else if (c == r) parent = saved_left;
         else parent = (saved_left > above) ? saved_left : above;
      end
      s = int'(v) + int'(parent);
      sum = (s > int'(SUM_MAX)) ? SUM_MAX : SUM_W'(s);
      saved_left = above;
      partial_sums[c] = sum;
      if (bottom && (c == 0 || sum > bottom_max)) bottom_max = sum;
      if (c >= r) begin
         if (bottom) begin
            expected_totals.push_back(bottom_max);
            cur_row = 0;
            bottom_max = '0;
         end else begin
            cur_row = r + 1;
         end
         cur_col = 0;
         saved_left = '0;
      end else begin
         cur_row = r;
         cur_col = c + 1;
      end
   endfunction

   always @(posedge clock) begin
      logic [SUM_W-1:0] want;
      if (reset) begin
         row_count = ROW_COUNT_RESET;
         for (int i = 0; i < MAX_ROWS; i++) partial_sums[i] = '0;
         cur_row = 0;
         cur_col = 0;
         saved_left = '0;
         bottom_max = '0;
         expected_totals.delete();
         failures = 0;
         totals_checked = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_totals.size() == 0) begin
               if (failures < 10) $display("%0t: max_total %0d with nothing expected",
                                           $realtime, rsp_max_total);
               failures++;
            end else begin
               want = expected_totals.pop_front();
               if (rsp_max_total !== want) begin
                  if (failures < 10) $display("%0t: max_total expected %0d, got %0d",
                                              $realtime, want, rsp_max_total);
                  failures++;
               end
               totals_checked++;
            end
         end
         if (csr_write_enable) row_count = csr_write_data;
         if (req_valid && !req_stall) fold_entry(req_value);
      end
      pending = expected_totals.size();
   end

endmodule

[tb/sv/testbench.sv]
// Top of the triangle maximum path sum testbench: clock, reset, stimulus, receiver
// stalls, watchdog and verdict. Depends on tmps_pkg, tmps_checker and the unit.
`timescale 1ns / 1ps

module testbench import tmps_pkg::*; ();

   localparam int QUIET_LIMIT   = 2000;
   localparam int HOLD_CYCLES   = 200;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_WORDS  = 800;

   logic               clock;
   logic               reset;
   logic               csr_write_enable;
   logic [CSR_W-1:0]   csr_write_data;
   logic               req_valid;
   logic [VALUE_W-1:0] req_value;
   logic               req_stall;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [SUM_W-1:0]   rsp_max_total;

   int               failures;
   int               pending;
   int               totals_checked;
   int               quiet_cycles;
   int               words_sent;
   int               burst_left;
   bit               steady;
   int               hold_asked;
   int               hold_served;
   logic [CSR_W-1:0] rows_setting;

   triangle_max_path_sum_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_value        (req_value),
      .req_stall        (req_stall),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_max_total    (rsp_max_total)
   );

   tmps_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_max_total    (rsp_max_total),
      .failures         (failures),
      .pending          (pending),
      .totals_checked   (totals_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int eff_rows(input logic [CSR_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > MAX_ROWS) return MAX_ROWS;
      return int'(raw);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value(input bit all_ones);
      if (all_ones) return '1;
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   // one word on req_, with bursts and gaps unless held steady
   task automatic offer(input logic [VALUE_W-1:0] v);
      if (!steady && burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) burst_left--;
      req_valid <= 1'b1;
      req_value <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_rows(input logic [CSR_W-1:0] v);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      rows_setting = v;
   endtask

   // whole triangle; with cut_at > 0 the row count changes after that many words
   task automatic send_triangle(input int cut_at, input logic [CSR_W-1:0] new_raw,
                                input bit all_ones);
      int eff;
      int target;
      int sent;
      int row;
      int col;
      int left;
      eff = eff_rows(rows_setting);
      target = (cut_at > 0) ? cut_at : eff * (eff + 1) / 2;
      row = 0;
      col = 0;
      for (sent = 0; sent < target; sent++) begin
         offer(pick_value(all_ones));
         if (col == row) begin
            row++;
            col = 0;
         end else begin
            col++;
         end
      end
      if (cut_at > 0) begin
         settle();
         write_rows(new_raw);
         eff = eff_rows(new_raw);
         left = row - col + 1;
         for (int rr = row + 1; rr < eff; rr++) left += rr + 1;
         repeat (left) offer(pick_value(all_ones));
      end
   endtask

   // receiver: stretches of no, light, heavy or full stall, plus requested long holds
   initial begin
      int stretch;
      int mode;
      rsp_stall <= 1'b0;
      hold_served = 0;
      @(posedge clock);
      forever begin
         if (hold_served != hold_asked) begin
            hold_served++;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            stretch = $urandom_range(8, 60);
            mode = $urandom_range(0, 3);
            for (int k = 0; k < stretch && hold_served == hold_asked; k++) begin
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 3) == 0);
                  2: rsp_stall <= ($urandom_range(0, 3) != 0);
                  default: rsp_stall <= 1'b1;
               endcase
               @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("triangle_max_path_sum_unit: mismatch");
      $finish;
   end

   initial begin
      int               random_base;
      int               kind;
      int               tri_n;
      int               total;
      int               cut;
      logic [CSR_W-1:0] raw;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_value        <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      words_sent       = 0;
      burst_left       = 0;
      steady           = 1'b0;
      hold_asked       = 0;
      rows_setting     = ROW_COUNT_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default row count straight out of reset
      send_triangle(0, '0, 1'b0);
      settle();

      // one-row triangles, then row count zero behaving as one row
      write_rows(CSR_W'(1));
      offer('0);
      offer('1);
      offer(VALUE_W'(1));
      offer(VALUE_W'(16'h8000));
      settle();
      write_rows('0);
      offer('1);
      offer('0);
      offer(VALUE_W'(16'h5A5A));
      offer(VALUE_W'(16'hA5A5));
      settle();

      write_rows(CSR_W'(3));
      offer(VALUE_W'(1));
      offer('1);
      offer('0);
      offer('0);
      offer('0);
      offer('1);
      settle();

      // row count lowered mid-triangle, still ahead of and already past the current row
      write_rows(CSR_W'(MAX_ROWS));
      send_triangle(3, CSR_W'(4), 1'b0);
      settle();
      write_rows(CSR_W'(6));
      send_triangle(8, CSR_W'(2), 1'b0);
      settle();

      // row count above the maximum, full-scale words
      write_rows('1);
      send_triangle(12, CSR_W'(5), 1'b1);
      settle();

      // receiver holds off while one-row triangles keep coming
      write_rows(CSR_W'(1));
      hold_asked++;
      while (hold_served != hold_asked) @(posedge clock);
      steady = 1'b1;
      repeat (40) offer(pick_value(1'b0));
      steady = 1'b0;
      settle();

      random_base = words_sent;
      while (words_sent < random_base + RANDOM_WORDS) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) raw = '0;
         else if (kind < 6) raw = CSR_W'($urandom_range(1, 6));
         else if (kind < 9) raw = CSR_W'($urandom_range(7, 16));
         else raw = CSR_W'($urandom_range(17, 24));
         write_rows(raw);
         tri_n = $urandom_range(1, 4);
         repeat (tri_n) begin
            total = eff_rows(rows_setting) * (eff_rows(rows_setting) + 1) / 2;
            cut = 0;
            if (total > 1 && $urandom_range(0, 4) == 0) cut = $urandom_range(1, total - 1);
            send_triangle(cut, CSR_W'($urandom_range(0, 12)), 1'b0);
         end
         settle();
      end

      settle();
      if (pending != 0) $display("%0d expected totals never arrived", pending);
      $display("sent %0d words, checked %0d totals", words_sent, totals_checked);
      $display("row counts 0 to 255 incl. saturation, mid-triangle changes, long rsp hold");
      if (failures == 0 && pending == 0) begin
         $display("triangle_max_path_sum_unit: match");
      end else begin
         $display("triangle_max_path_sum_unit: mismatch");
      end
      $finish;
   end

endmodule
